### hw/rtl/distance_pd_drive_top_macros.svh
// Assertion helpers for the top-level RTL. Each expects clk and arst_n in scope.
`ifndef DISTANCE_PD_DRIVE_TOP_MACROS_SVH
`define DISTANCE_PD_DRIVE_TOP_MACROS_SVH

// same-cycle implication
`define DPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/dpd_pkg.sv
package dpd_pkg;

	localparam int TIME_BITS_DEFAULT = 32;

	localparam int TOL_MM      = 5;
	localparam int SETTLE_MS   = 55;
	localparam int FAR_MM      = 9910;
	localparam int DEFAULT_MIN = 15;

	localparam int DIST_W  = 14;
	localparam int STAMP_W = 32;
	localparam int ERR_W   = 15;
	localparam int GAIN_W  = 10;
	localparam int SPEED_W = 7;
	localparam int POWER_W = 8;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic KIND_START  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [2:0] REG_TARGET   = 3'd0;
	localparam logic [2:0] REG_FWD      = 3'd1;
	localparam logic [2:0] REG_WANT_DEC = 3'd2;
	localparam logic [2:0] REG_MAX_SPD  = 3'd3;
	localparam logic [2:0] REG_MIN_SPD  = 3'd4;
	localparam logic [2:0] REG_TIMEOUT  = 3'd5;
	localparam logic [2:0] REG_KP       = 3'd6;
	localparam logic [2:0] REG_KD       = 3'd7;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_TIMEOUT = 2'd1,
		CAUSE_FAULT   = 2'd2,
		CAUSE_SETTLED = 2'd3
	} cause_t;

	typedef struct packed {
		logic [DIST_W-1:0]  target_mm;
		logic               move_forwards;
		logic               want_decreasing;
		logic [SPEED_W-1:0] max_speed;
		logic [SPEED_W-1:0] min_speed;
		logic [STAMP_W-1:0] timeout_ms;
		logic [GAIN_W-1:0]  kp_q8;
		logic [GAIN_W-1:0]  kd_q8;
	} cfg_t;

endpackage

### hw/rtl/dpd_cfg.sv
module dpd_cfg
	import dpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_mm       <= '0;
			cfg_q.move_forwards   <= 1'b1;
			cfg_q.want_decreasing <= 1'b1;
			cfg_q.max_speed       <= 7'd127;
			cfg_q.min_speed       <= '0;
			cfg_q.timeout_ms      <= 32'd3000;
			cfg_q.kp_q8           <= 10'd72;
			cfg_q.kd_q8           <= 10'd174;
		end else if (wr_en) begin
			unique case (idx)
				REG_TARGET:   cfg_q.target_mm       <= pwdata[DIST_W-1:0];
				REG_FWD:      cfg_q.move_forwards   <= pwdata[0];
				REG_WANT_DEC: cfg_q.want_decreasing <= pwdata[0];
				REG_MAX_SPD:  cfg_q.max_speed       <= pwdata[SPEED_W-1:0];
				REG_MIN_SPD:  cfg_q.min_speed       <= pwdata[SPEED_W-1:0];
				REG_TIMEOUT:  cfg_q.timeout_ms      <= pwdata[STAMP_W-1:0];
				REG_KP:       cfg_q.kp_q8           <= pwdata[GAIN_W-1:0];
				REG_KD:       cfg_q.kd_q8           <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET:   prdata = DATA_W'(cfg_q.target_mm);
			REG_FWD:      prdata = DATA_W'(cfg_q.move_forwards);
			REG_WANT_DEC: prdata = DATA_W'(cfg_q.want_decreasing);
			REG_MAX_SPD:  prdata = DATA_W'(cfg_q.max_speed);
			REG_MIN_SPD:  prdata = DATA_W'(cfg_q.min_speed);
			REG_TIMEOUT:  prdata = DATA_W'(cfg_q.timeout_ms);
			REG_KP:       prdata = DATA_W'(cfg_q.kp_q8);
			REG_KD:       prdata = DATA_W'(cfg_q.kd_q8);
			default:      prdata = '0;
		endcase
	end

endmodule

### hw/rtl/dpd_pd.sv
module dpd_pd
	import dpd_pkg::*;
(
	input  cfg_t                     cfg,
	input  logic signed [ERR_W-1:0]  err,
	input  logic signed [ERR_W-1:0]  last_err,
	output logic signed [POWER_W-1:0] power
);

	localparam int PW = 2 * ERR_W - 3; // 27 bits hold kp*e + kd*d

	logic signed [ERR_W:0]      deriv;
	logic signed [GAIN_W:0]     kp_s, kd_s;
	logic signed [PW-2:0]       p_term;
	logic signed [PW-2:0]       d_term;
	logic signed [PW-1:0]       p_sum, p_clip, lim;
	logic        [SPEED_W-1:0]  minv;
	logic        [ERR_W-1:0]    abs_p, floor_q8, abs_l;
	logic                       neg;
	logic        [SPEED_W-1:0]  mag;

	assign deriv  = (ERR_W+1)'(err) - (ERR_W+1)'(last_err);
	assign kp_s   = $signed({1'b0, cfg.kp_q8});
	assign kd_s   = $signed({1'b0, cfg.kd_q8});
	assign p_term = (PW-1)'(kp_s) * (PW-1)'(err);
	assign d_term = (PW-1)'(kd_s) * (PW-1)'(deriv);
	assign p_sum  = PW'(p_term) + PW'(d_term);
	assign lim    = $signed(PW'({cfg.max_speed, 8'h00}));

	always_comb begin
		if (p_sum > lim) begin
			p_clip = lim;
		end else if (p_sum < -lim) begin
			p_clip = -lim;
		end else begin
			p_clip = p_sum;
		end
	end

	assign minv     = (cfg.min_speed != '0) ? cfg.min_speed : SPEED_W'(DEFAULT_MIN);
	assign neg      = p_clip < 0;
	assign abs_p    = neg ? ERR_W'(-p_clip) : ERR_W'(p_clip);
	assign floor_q8 = {minv, 8'h00};
	// nonzero but below the floor gets lifted, may exceed max_speed
	assign abs_l    = (abs_p != '0 && abs_p < floor_q8) ? floor_q8 : abs_p;
	assign mag      = abs_l[ERR_W-1:8];

	always_comb begin
		if (neg ^ !cfg.move_forwards) begin
			power = -$signed({1'b0, mag});
		end else begin
			power = $signed({1'b0, mag});
		end
	end

endmodule

### hw/rtl/distance_pd_drive_top.sv
// Distance PD drive with settle detection.
// Input channel (in_valid/in_ready): a beat is a start command (kind 0) or a
// sensor sample (kind 1) with distance_mm, sensor_fault and now_ms.
// Output channel (out_valid/out_ready): one beat per input beat carrying
// motor_power, finished and finish_cause, in input order.
// An accepted beat is held in the input register, and out_valid rises when
// the step result is loaded into the result register. The whole
// step (timeout, fault, range, settle, PD multiply, clamp and floor) is
// evaluated from the input register into the result register.
// Throughput is one beat per cycle while out_ready is high; the loop is the
// move state (last_error, settle, run, cause), updated in the same cycle the step retires.
// If out_ready is low the result register holds, the input register fills,
// and in_ready drops only when both are occupied.
// Reset clears the move state (idle, no end cause) and loads the register
// defaults; both stages come up empty.
// Configuration goes through the APB port, one 32-bit register per word, and
// must be written by the user only while no beat is in flight (not enforced).
`include "distance_pd_drive_top_macros.svh"

module distance_pd_drive_top
	import dpd_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [DIST_W-1:0]         distance_mm,
	input  logic                      sensor_fault,
	input  logic [STAMP_W-1:0]        now_ms,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [POWER_W-1:0] motor_power,
	output logic                      finished,
	output logic [1:0]                finish_cause
);

	cfg_t cfg;

	dpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	logic               valid_s1;
	logic               kind_s1;
	logic [DIST_W-1:0]  dist_s1;
	logic               fault_s1;
	logic [STAMP_W-1:0] now_s1;
	logic               adv_s1;

	// move state
	logic signed [ERR_W-1:0] last_err_q, last_err_d;
	logic [TIME_BITS-1:0]    move_start_q, move_start_d;
	logic [TIME_BITS-1:0]    settle_start_q, settle_start_d;
	logic                    in_band_q, in_band_d;
	logic                    running_q, running_d;
	cause_t                  end_cause_q, end_cause_d;

	// result register
	logic                      out_valid_q;
	logic signed [POWER_W-1:0] power_q, power_d;
	logic                      fin_q, fin_d;
	cause_t                    cause_q, cause_d;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			dist_s1  <= distance_mm;
			fault_s1 <= sensor_fault;
			now_s1   <= now_ms;
		end
	end

	// step evaluation
	logic [63:0]             now_wide;
	logic [TIME_BITS-1:0]    now_t, elapsed, settle_el;
	logic                    timeout_hit, far, in_tol, settle_done;
	logic signed [ERR_W-1:0] err, dist_e, tgt_e;
	logic signed [POWER_W-1:0] pd_power;

	assign now_wide    = {32'b0, now_s1};
	assign now_t       = now_wide[TIME_BITS-1:0];
	assign elapsed     = now_t - move_start_q;
	assign settle_el   = now_t - settle_start_q;
	assign timeout_hit = 64'(elapsed) > 64'(cfg.timeout_ms);
	assign far         = dist_s1 >= DIST_W'(FAR_MM);
	assign dist_e      = $signed({1'b0, dist_s1});
	assign tgt_e       = $signed({1'b0, cfg.target_mm});
	assign err         = cfg.want_decreasing ? (dist_e - tgt_e) : (tgt_e - dist_e);
	assign in_tol      = (err <= ERR_W'(TOL_MM)) && (err >= -ERR_W'(TOL_MM));
	assign settle_done = 64'(settle_el) >= 64'(SETTLE_MS);

	dpd_pd u_pd (
		.cfg      (cfg),
		.err      (err),
		.last_err (last_err_q),
		.power    (pd_power)
	);

	always_comb begin
		last_err_d     = last_err_q;
		move_start_d   = move_start_q;
		settle_start_d = settle_start_q;
		in_band_d      = in_band_q;
		running_d      = running_q;
		end_cause_d    = end_cause_q;
		power_d        = '0;
		fin_d          = 1'b0;
		cause_d        = CAUSE_NONE;

		if (kind_s1 == KIND_START) begin
			running_d    = 1'b1;
			move_start_d = now_t;
			in_band_d    = 1'b0;
			last_err_d   = '0;
			end_cause_d  = CAUSE_NONE;
		end else if (!running_q) begin
			fin_d   = end_cause_q != CAUSE_NONE;
			cause_d = end_cause_q;
		end else if (timeout_hit || fault_s1) begin
			running_d   = 1'b0;
			end_cause_d = timeout_hit ? CAUSE_TIMEOUT : CAUSE_FAULT;
			fin_d       = 1'b1;
			cause_d     = end_cause_d;
		end else if (far) begin
			// approach at full speed, settle tracking untouched
			last_err_d = '0;
			power_d    = cfg.move_forwards ? $signed({1'b0, cfg.max_speed})
			                               : -$signed({1'b0, cfg.max_speed});
		end else if (in_tol && in_band_q && settle_done) begin
			running_d   = 1'b0;
			end_cause_d = CAUSE_SETTLED;
			fin_d       = 1'b1;
			cause_d     = CAUSE_SETTLED;
		end else begin
			if (in_tol) begin
				if (!in_band_q) begin
					settle_start_d = now_t;
					in_band_d      = 1'b1;
				end
			end else begin
				in_band_d = 1'b0;
			end
			last_err_d = err;
			power_d    = pd_power;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q     <= '0;
			move_start_q   <= '0;
			settle_start_q <= '0;
			in_band_q      <= 1'b0;
			running_q      <= 1'b0;
			end_cause_q    <= CAUSE_NONE;
		end else if (adv_s1) begin
			last_err_q     <= last_err_d;
			move_start_q   <= move_start_d;
			settle_start_q <= settle_start_d;
			in_band_q      <= in_band_d;
			running_q      <= running_d;
			end_cause_q    <= end_cause_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			power_q <= power_d;
			fin_q   <= fin_d;
			cause_q <= cause_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign motor_power  = power_q;
	assign finished     = fin_q;
	assign finish_cause = cause_q;

	`DPD_ASSERT_NOW(a_fin_zero_power, out_valid_q && fin_q, power_q == '0, "finished beat with power")
	`DPD_ASSERT_NOW(a_fin_cause, out_valid_q, fin_q == (cause_q != CAUSE_NONE), "finished and cause disagree")
	`DPD_ASSERT_NOW(a_power_range, out_valid_q, power_q != -8'sd128, "power out of range")
	`DPD_ASSERT_NXT(a_start_arms, adv_s1 && kind_s1 == KIND_START, running_q && end_cause_q == CAUSE_NONE, "start did not arm")
	`DPD_ASSERT_NXT(a_end_idles, adv_s1 && fin_d && running_q, !running_q, "move end did not idle")

endmodule

### dv/distance_pd_drive_top_tb.sv
module distance_pd_drive_top_tb;
	import dpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 100;

	typedef struct {
		logic               kind;
		logic [DIST_W-1:0]  dist_mm;
		logic               fault;
		logic [STAMP_W-1:0] stamp;
	} drive_cmd_t;

	typedef struct {
		logic signed [POWER_W-1:0] power;
		logic                      fin;
		cause_t                    cause;
	} drive_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [DATA_W-1:0]         pwdata = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      kind = 1'b0;
	logic [DIST_W-1:0]         distance_mm = '0;
	logic                      sensor_fault = 1'b0;
	logic [STAMP_W-1:0]        now_ms = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [POWER_W-1:0] motor_power;
	logic                      finished;
	logic [1:0]                finish_cause;

	distance_pd_drive_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.distance_mm  (distance_mm),
		.sensor_fault (sensor_fault),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.motor_power  (motor_power),
		.finished     (finished),
		.finish_cause (finish_cause)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of the registers and the move state
	cfg_t                     drive_cfg;
	logic signed [ERR_W-1:0]  prev_err = '0;
	logic [STAMP_W-1:0]       move_t0 = '0;
	logic [STAMP_W-1:0]       band_t0 = '0;
	logic                     band_on = 1'b0;
	logic                     moving = 1'b0;
	cause_t                   stop_cause = CAUSE_NONE;

	drive_cmd_t  cmd_q[$];
	drive_beat_t drive_due[$];
	drive_cmd_t  cur_cmd;
	int          n_sent = 0;
	int          n_acc = 0;
	int          bad_beats = 0;
	int          in_gap = 0;
	int          in_quiet = 0;
	int          out_gap = 0;
	int          out_quiet = 0;
	int          hold_left = 0;
	int          holds_done = 0;
	int          idle_cycles = 0;
	logic [STAMP_W-1:0] now_t = '0;

	function automatic drive_beat_t end_move(input cause_t why);
		drive_beat_t r;
		moving = 1'b0;
		stop_cause = why;
		r.power = '0;
		r.fin = 1'b1;
		r.cause = why;
		return r;
	endfunction

	function automatic drive_beat_t pd_step(input drive_cmd_t c);
		drive_beat_t r;
		logic [STAMP_W-1:0] dt;
		int err;
		int deriv;
		int minv;
		longint p;
		longint lim;
		longint mag;
		longint pw;
		r.power = '0;
		r.fin = 1'b0;
		r.cause = CAUSE_NONE;
		if (c.kind == KIND_START) begin
			moving = 1'b1;
			move_t0 = c.stamp;
			band_on = 1'b0;
			prev_err = '0;
			stop_cause = CAUSE_NONE;
			return r;
		end
		if (!moving) begin
			r.fin = (stop_cause != CAUSE_NONE);
			r.cause = stop_cause;
			return r;
		end
		dt = c.stamp - move_t0;
		if (dt > drive_cfg.timeout_ms)
			return end_move(CAUSE_TIMEOUT);
		if (c.fault)
			return end_move(CAUSE_FAULT);
		if (c.dist_mm >= FAR_MM) begin
			prev_err = '0;
			pw = drive_cfg.move_forwards ? longint'(drive_cfg.max_speed)
				: -longint'(drive_cfg.max_speed);
			r.power = pw[POWER_W-1:0];
			return r;
		end
		err = drive_cfg.want_decreasing ? int'(c.dist_mm) - int'(drive_cfg.target_mm)
			: int'(drive_cfg.target_mm) - int'(c.dist_mm);
		if (err <= TOL_MM && err >= -TOL_MM) begin
			if (!band_on) begin
				band_t0 = c.stamp;
				band_on = 1'b1;
			end else begin
				dt = c.stamp - band_t0;
				if (dt >= SETTLE_MS)
					return end_move(CAUSE_SETTLED);
			end
		end else begin
			band_on = 1'b0;
		end
		deriv = err - int'(prev_err);
		p = longint'(drive_cfg.kp_q8) * err + longint'(drive_cfg.kd_q8) * deriv;
		lim = longint'(drive_cfg.max_speed) * 256;
		if (p > lim)
			p = lim;
		else if (p < -lim)
			p = -lim;
		minv = (drive_cfg.min_speed != 0) ? int'(drive_cfg.min_speed) : DEFAULT_MIN;
		// floor lift can overshoot the clamp when min > max
		if (p != 0 && (p > 0 ? p : -p) < longint'(minv) * 256)
			p = (p > 0) ? longint'(minv) * 256 : -longint'(minv) * 256;
		mag = (p > 0 ? p : -p) >> 8;
		pw = (p < 0) ? -mag : mag;
		if (!drive_cfg.move_forwards)
			pw = -pw;
		prev_err = err[ERR_W-1:0];
		r.power = pw[POWER_W-1:0];
		return r;
	endfunction

	// mostly short gaps, a few long ones, and quiet stretches with none
	function automatic int idle_len(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= 1'b0;
			distance_mm <= '0;
			sensor_fault <= 1'b0;
			now_ms <= '0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				drive_due.push_back(pd_step(cur_cmd));
				n_acc++;
				offer = 1'b0;
				in_gap = idle_len(in_quiet);
			end
			if (!offer) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (cmd_q.size() != 0) begin
					cur_cmd = cmd_q.pop_front();
					kind <= cur_cmd.kind;
					distance_mm <= cur_cmd.dist_mm;
					sensor_fault <= cur_cmd.fault;
					now_ms <= cur_cmd.stamp;
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	// output monitor and ready generator
	always @(posedge clk or negedge arst_n) begin
		drive_beat_t e;
		logic rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_due.size() == 0) begin
					if (bad_beats < 10)
						$display("unexpected beat: power %0d finished %0b cause %0d",
							motor_power, finished, finish_cause);
					bad_beats++;
				end else begin
					e = drive_due.pop_front();
					if (motor_power !== e.power || finished !== e.fin ||
						finish_cause !== e.cause) begin
						if (bad_beats < 10)
							$display("mismatch: power %0d/%0d finished %0b/%0b cause %0d/%0d (exp/got)",
								e.power, motor_power, e.fin, finished, e.cause, finish_cause);
						bad_beats++;
					end
				end
			end
			// long hold-off while the sender still has plenty queued
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (holds_done < 2 && cmd_q.size() > 30) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
				rdy = 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				out_gap = idle_len(out_quiet);
			end
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TARGET:   drive_cfg.target_mm = val[DIST_W-1:0];
			REG_FWD:      drive_cfg.move_forwards = val[0];
			REG_WANT_DEC: drive_cfg.want_decreasing = val[0];
			REG_MAX_SPD:  drive_cfg.max_speed = val[SPEED_W-1:0];
			REG_MIN_SPD:  drive_cfg.min_speed = val[SPEED_W-1:0];
			REG_TIMEOUT:  drive_cfg.timeout_ms = val[STAMP_W-1:0];
			REG_KP:       drive_cfg.kp_q8 = val[GAIN_W-1:0];
			REG_KD:       drive_cfg.kd_q8 = val[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_cfg(input cfg_t c);
		apb_write(REG_TARGET, DATA_W'(c.target_mm));
		apb_write(REG_FWD, DATA_W'(c.move_forwards));
		apb_write(REG_WANT_DEC, DATA_W'(c.want_decreasing));
		apb_write(REG_MAX_SPD, DATA_W'(c.max_speed));
		apb_write(REG_MIN_SPD, DATA_W'(c.min_speed));
		apb_write(REG_TIMEOUT, DATA_W'(c.timeout_ms));
		apb_write(REG_KP, DATA_W'(c.kp_q8));
		apb_write(REG_KD, DATA_W'(c.kd_q8));
		@(negedge clk);
	endtask

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.target_mm = DIST_W'($urandom_range(0, 9999));
		c.move_forwards = 1'($urandom_range(0, 1));
		c.want_decreasing = 1'($urandom_range(0, 1));
		c.max_speed = SPEED_W'(($urandom_range(0, 3) == 0) ? 127 : $urandom_range(1, 127));
		case ($urandom_range(0, 5))
			0, 1, 2: c.min_speed = '0;
			3:       c.min_speed = 7'd127;
			default: c.min_speed = SPEED_W'($urandom_range(1, 126));
		endcase
		case ($urandom_range(0, 9))
			0:       c.timeout_ms = 32'hFFFF_FFFF;
			1:       c.timeout_ms = $urandom_range(0, 40);
			default: c.timeout_ms = $urandom_range(150, 3000);
		endcase
		c.kp_q8 = GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
			: $urandom_range(0, 1023));
		c.kd_q8 = GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, 255)
			: $urandom_range(0, 1023));
		return c;
	endfunction

	// only called right after a falling edge, so the driver never races it
	task automatic push_cmd(input logic k, input int d, input logic f,
		input logic [STAMP_W-1:0] t);
		drive_cmd_t c;
		c.kind = k;
		c.dist_mm = d[DIST_W-1:0];
		c.fault = f;
		c.stamp = t;
		cmd_q.push_back(c);
		n_sent++;
	endtask

	// one move: start, then noisy readings, mostly converging on the target
	task automatic gen_move(input int n);
		int d;
		int tgt;
		int r;
		tgt = int'(drive_cfg.target_mm);
		now_t += $urandom_range(1, 500);
		push_cmd(KIND_START, $urandom_range(0, 9999), 1'($urandom_range(0, 1)), now_t);
		d = $urandom_range(0, 9999);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			now_t += $urandom_range(5, 30);
			if (r < 3) begin
				push_cmd(KIND_SAMPLE, $urandom_range(0, 9999), 1'b1, now_t);
			end else if (r < 8) begin
				push_cmd(KIND_SAMPLE, $urandom_range(FAR_MM, 9999), 1'b0, now_t);
			end else if (r < 10) begin
				now_t += $urandom;
				push_cmd(KIND_SAMPLE, d, 1'b0, now_t);
			end else if (r < 12) begin
				push_cmd(KIND_START, d, 1'b0, now_t);
			end else begin
				d = tgt + (d - tgt) / 2 + int'($urandom_range(0, 6)) - 3;
				if (d < 0)
					d = 0;
				if (d > 9999)
					d = 9999;
				push_cmd(KIND_SAMPLE, d, 1'b0, now_t);
			end
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (n_acc != n_sent || drive_due.size() != 0);
	endtask

	initial begin
		int goal;
		drive_cfg = '{target_mm: 14'd0, move_forwards: 1'b1, want_decreasing: 1'b1,
			max_speed: 7'd127, min_speed: 7'd0, timeout_ms: 32'd3000,
			kp_q8: 10'd72, kd_q8: 10'd174};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset register values
		push_cmd(KIND_SAMPLE, 0, 1'b0, 32'd0);          // no move yet
		push_cmd(KIND_START, 0, 1'b0, 32'd1000);
		push_cmd(KIND_SAMPLE, 9999, 1'b0, 32'd1010);    // out of range
		push_cmd(KIND_SAMPLE, FAR_MM, 1'b0, 32'd1020);
		push_cmd(KIND_SAMPLE, FAR_MM - 1, 1'b0, 32'd1030);
		push_cmd(KIND_SAMPLE, 3, 1'b0, 32'd1040);       // enters band
		push_cmd(KIND_SAMPLE, 0, 1'b0, 32'd1060);
		push_cmd(KIND_SAMPLE, 6, 1'b0, 32'd1070);       // leaves band
		push_cmd(KIND_SAMPLE, 5, 1'b0, 32'd1080);
		push_cmd(KIND_SAMPLE, 0, 1'b0, 32'd1134);       // 54 ms, still running
		push_cmd(KIND_SAMPLE, 2, 1'b0, 32'd1135);       // 55 ms, settled
		push_cmd(KIND_SAMPLE, 2, 1'b0, 32'd1140);
		push_cmd(KIND_START, 0, 1'b0, 32'hFFFF_FF00);
		push_cmd(KIND_SAMPLE, 50, 1'b1, 32'hFFFF_FF10); // fault
		push_cmd(KIND_START, 9999, 1'b1, 32'hFFFF_FFF0);
		push_cmd(KIND_SAMPLE, 100, 1'b0, 32'h0000_0010); // stamp wrapped
		push_cmd(KIND_SAMPLE, 100, 1'b0, 32'd2984);     // exactly at timeout
		push_cmd(KIND_SAMPLE, 100, 1'b1, 32'd2985);     // timeout beats fault
		push_cmd(KIND_START, 0, 1'b0, 32'd5000);
		push_cmd(KIND_SAMPLE, 9999, 1'b1, 32'd5010);    // fault beats range
		push_cmd(KIND_START, 0, 1'b0, 32'd6000);
		push_cmd(KIND_SAMPLE, 200, 1'b0, 32'd6010);
		push_cmd(KIND_START, 0, 1'b0, 32'd6020);        // restart mid-move
		push_cmd(KIND_SAMPLE, 200, 1'b0, 32'd6030);
		drain();

		// min above max, no timeout, full gains
		write_cfg('{target_mm: 14'd9999, move_forwards: 1'b0, want_decreasing: 1'b0,
			max_speed: 7'd10, min_speed: 7'd127, timeout_ms: 32'hFFFF_FFFF,
			kp_q8: 10'd1023, kd_q8: 10'd1023});
		now_t = 32'hFFFF_FE00;
		repeat (3) gen_move(6);
		drain();

		// zero everything, zero timeout
		write_cfg('{target_mm: 14'd0, move_forwards: 1'b1, want_decreasing: 1'b0,
			max_speed: 7'd0, min_speed: 7'd0, timeout_ms: 32'd0,
			kp_q8: 10'd0, kd_q8: 10'd0});
		repeat (2) gen_move(3);
		push_cmd(KIND_START, 0, 1'b0, now_t);
		push_cmd(KIND_SAMPLE, 0, 1'b0, now_t);
		drain();

		write_cfg('{target_mm: 14'd5000, move_forwards: 1'b1, want_decreasing: 1'b1,
			max_speed: 7'd127, min_speed: 7'd1, timeout_ms: 32'd500,
			kp_q8: 10'd0, kd_q8: 10'd0});
		repeat (2) gen_move(10);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(rand_cfg());
			now_t = $urandom;
			goal = n_sent + 100;
			while (n_sent < goal) begin
				gen_move($urandom_range(2, 25));
				if ($urandom_range(0, 9) == 0)
					push_cmd(KIND_SAMPLE, $urandom_range(0, 9999),
						1'($urandom_range(0, 1)), $urandom);
			end
			drain();
		end

		repeat (5) @(posedge clk);
		if (bad_beats == 0 && drive_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_cfg.sv
hw/rtl/dpd_pd.sv
hw/rtl/distance_pd_drive_top.sv
dv/distance_pd_drive_top_tb.sv
